[src/rrr_pkg.sv]
// rrr_pkg: shared constants for the ray reflect / refract unit
// no dependencies; imported by the pipelined arithmetic units and the top level
package rrr_pkg;

	localparam int NUM_LANES = 3;
	localparam int SQRT_GRP  = 4;
	localparam int DIV_GRP   = 4;

endpackage

[src/rrr_ray_if.sv]
// rrr_ray_if: input transaction channel, one ray with command and index
// standalone; widths follow FRAC_BITS
interface rrr_ray_if #(parameter int FRAC_BITS = 16);

	logic                         valid;
	logic                         ready;
	logic                         command;
	logic signed [FRAC_BITS+1:0]  dir_x;
	logic signed [FRAC_BITS+1:0]  dir_y;
	logic signed [FRAC_BITS+1:0]  dir_z;
	logic signed [FRAC_BITS+1:0]  norm_x;
	logic signed [FRAC_BITS+1:0]  norm_y;
	logic signed [FRAC_BITS+1:0]  norm_z;
	logic        [FRAC_BITS+3:0]  index_ratio;

	modport source (
		output valid, command, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_ratio,
		input  ready
	);
	modport sink (
		input  valid, command, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_ratio,
		output ready
	);

endinterface

[src/rrr_res_if.sv]
// rrr_res_if: result transaction channel, one output direction and flag
// standalone; widths follow FRAC_BITS
interface rrr_res_if #(parameter int FRAC_BITS = 16);

	logic                         valid;
	logic                         ready;
	logic signed [FRAC_BITS+1:0]  out_x;
	logic signed [FRAC_BITS+1:0]  out_y;
	logic signed [FRAC_BITS+1:0]  out_z;
	logic                         refracted_flag;

	modport source (
		output valid, out_x, out_y, out_z, refracted_flag,
		input  ready
	);
	modport sink (
		input  valid, out_x, out_y, out_z, refracted_flag,
		output ready
	);

endinterface

[src/rrr_sqrt_pipe.sv]
// rrr_sqrt_pipe: pipelined digit-by-digit integer square root with sideband
// depends on rrr_pkg (SQRT_GRP steps per stage)
module rrr_sqrt_pipe #(
	parameter int XW  = 46,
	parameter int SBW = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [XW-1:0]    x,
	input  logic [SBW-1:0]   sb_in,
	output logic             out_valid,
	output logic [XW/2-1:0]  root,
	output logic [SBW-1:0]   sb_out
);
	import rrr_pkg::*;

	localparam int STEPS = XW / 2;
	localparam int REMW  = STEPS + 2;
	localparam int TMPW  = STEPS + 4;
	localparam int L     = (STEPS + SQRT_GRP - 1) / SQRT_GRP;

	logic [XW-1:0]    x_st    [L+1];
	logic [STEPS-1:0] root_st [L+1];
	logic [REMW-1:0]  rem_st  [L+1];
	logic [SBW-1:0]   sb_st   [L+1];
	logic             v_st    [L+1];

	assign x_st[0]    = x;
	assign root_st[0] = '0;
	assign rem_st[0]  = '0;
	assign sb_st[0]   = sb_in;
	assign v_st[0]    = in_valid;

	for (genvar s = 0; s < L; s++) begin : g_stage
		logic [XW-1:0]    xn;
		logic [STEPS-1:0] rn;
		logic [REMW-1:0]  mn;
		logic [TMPW-1:0]  tmp;
		logic [TMPW-1:0]  trial;

		always_comb begin
			xn    = x_st[s];
			rn    = root_st[s];
			mn    = rem_st[s];
			tmp   = '0;
			trial = '0;
			for (int j = 0; j < SQRT_GRP; j++) begin
				if (s * SQRT_GRP + j < STEPS) begin
					tmp   = {mn, xn[XW-1:XW-2]};
					trial = TMPW'({rn, 2'b01});
					if (tmp >= trial) begin
						mn = REMW'(tmp - trial);
						rn = {rn[STEPS-2:0], 1'b1};
					end else begin
						mn = REMW'(tmp);
						rn = {rn[STEPS-2:0], 1'b0};
					end
					xn = xn << 2;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_st[s+1] <= 1'b0;
			end else if (en) begin
				v_st[s+1] <= v_st[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_st[s+1]    <= xn;
				root_st[s+1] <= rn;
				rem_st[s+1]  <= mn;
				sb_st[s+1]   <= sb_st[s];
			end
		end
	end

	assign out_valid = v_st[L];
	assign root      = root_st[L];
	assign sb_out    = sb_st[L];

endmodule

[src/rrr_div_pipe.sv]
// rrr_div_pipe: pipelined restoring divider, three lanes sharing one divisor
// depends on rrr_pkg (NUM_LANES, DIV_GRP); flags quotients that need more than QB bits
module rrr_div_pipe #(
	parameter int UW  = 45,
	parameter int DW  = 20,
	parameter int QB  = 18,
	parameter int SBW = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic [rrr_pkg::NUM_LANES-1:0][UW-1:0] num,
	input  logic [DW-1:0]                        divisor,
	input  logic [SBW-1:0]                       sb_in,
	output logic                                 out_valid,
	output logic [rrr_pkg::NUM_LANES-1:0][QB-1:0] quo,
	output logic [rrr_pkg::NUM_LANES-1:0]         ovf,
	output logic [SBW-1:0]                       sb_out
);
	import rrr_pkg::*;

	localparam int HW = UW - QB;
	localparam int CW = (HW > DW) ? HW : DW;
	localparam int L  = (QB + DIV_GRP - 1) / DIV_GRP;

	logic [QB-1:0]  lo_st  [L+1][NUM_LANES];
	logic [DW-1:0]  rem_st [L+1][NUM_LANES];
	logic           ovf_st [L+1][NUM_LANES];
	logic [DW-1:0]  dv_st  [L+1];
	logic [SBW-1:0] sb_st  [L+1];
	logic           v_st   [L+1];

	// first stage: overflow check and initial partial remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_st[0] <= 1'b0;
		end else if (en) begin
			v_st[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				ovf_st[0][i] <= CW'(num[i][UW-1:QB]) >= CW'(divisor);
				rem_st[0][i] <= DW'(num[i][UW-1:QB]);
				lo_st[0][i]  <= num[i][QB-1:0];
			end
			dv_st[0] <= divisor;
			sb_st[0] <= sb_in;
		end
	end

	for (genvar s = 0; s < L; s++) begin : g_stage
		logic [DW-1:0] rn [NUM_LANES];
		logic [QB-1:0] ln [NUM_LANES];
		logic [DW:0]   tmp;

		always_comb begin
			tmp = '0;
			for (int i = 0; i < NUM_LANES; i++) begin
				rn[i] = rem_st[s][i];
				ln[i] = lo_st[s][i];
				for (int j = 0; j < DIV_GRP; j++) begin
					if (s * DIV_GRP + j < QB) begin
						tmp   = {rn[i], ln[i][QB-1]};
						ln[i] = ln[i] << 1;
						if (tmp >= {1'b0, dv_st[s]}) begin
							rn[i]    = DW'(tmp - {1'b0, dv_st[s]});
							ln[i][0] = 1'b1;
						end else begin
							rn[i] = tmp[DW-1:0];
						end
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_st[s+1] <= 1'b0;
			end else if (en) begin
				v_st[s+1] <= v_st[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < NUM_LANES; i++) begin
					rem_st[s+1][i] <= rn[i];
					lo_st[s+1][i]  <= ln[i];
					ovf_st[s+1][i] <= ovf_st[s][i];
				end
				dv_st[s+1] <= dv_st[s];
				sb_st[s+1] <= sb_st[s];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			quo[i] = lo_st[L][i];
			ovf[i] = ovf_st[L][i];
		end
	end

	assign out_valid = v_st[L];
	assign sb_out    = sb_st[L];

endmodule

[src/ray_reflect_refract_unit.sv]
// ray_reflect_refract_unit: fixed-point mirror reflection and vector Snell refraction
// depends on rrr_pkg, rrr_ray_if, rrr_res_if, rrr_sqrt_pipe, rrr_div_pipe
//
// usage:
//   ray    : input transactions (command, direction, normal, index ratio)
//   result : output transactions (direction, refracted flag), one per input,
//            in order
//   every result comes from one input; there is no state between rays
//   internal precision: P = min(FRAC_BITS, 26) fraction bits
//   throughput: one transaction per cycle while result.ready allows, set by
//            the fully pipelined square root (four root digits per stage)
//            and divider (four quotient bits per stage), three lanes of the
//            divider side by side
//   ray.ready is high while the output register is empty or being taken;
//   when result.ready is low with a result waiting, the whole pipeline holds
//   and nothing is lost or repeated
//   reset (arst_n low) clears every stage valid bit; no result is pending
//   after reset
module ray_reflect_refract_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	rrr_ray_if.sink   ray,
	rrr_res_if.source result
);
	import rrr_pkg::*;

	localparam int P    = (FRAC_BITS < 26) ? FRAC_BITS : 26;
	localparam int H    = FRAC_BITS - P;
	localparam int OW   = FRAC_BITS + 2;
	localparam int VW   = P + 2;
	localparam int NW   = P + 4;
	localparam int PW   = 2 * VW;
	localparam int SUMW = PW + 2;
	localparam int DOTW = SUMW - P;
	localparam int TW   = VW + DOTW;
	localparam int CCW  = 2 * DOTW;
	localparam int NNW  = 2 * NW;
	localparam int RW   = P + 10;
	localparam int RADW = 2 * P + 14;
	localparam int KW   = RADW / 2;
	localparam int MW   = KW + 2;
	localparam int AW   = 2 * P + 13;
	localparam int QB   = P + 2;

	localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
	localparam logic signed [RW-1:0] RMAX = RW'(VMAX);
	localparam logic signed [RW-1:0] RMIN = RW'(VMIN);
	localparam logic [QB-1:0]        QLIM = {1'b1, {(QB-1){1'b0}}};
	localparam logic [OW-1:0]        OMAX = {1'b0, {(OW-1){1'b1}}};

	typedef struct packed {
		logic [NUM_LANES-1:0][VW-1:0] d;
		logic [NUM_LANES-1:0][VW-1:0] nv;
		logic [NW-1:0]                n;
		logic                         cmd;
		logic [DOTW-1:0]              dot;
		logic [NUM_LANES-1:0][RW-1:0] r;
		logic                         tir;
	} sq_sb_t;

	typedef struct packed {
		logic [NUM_LANES-1:0]         neg;
		logic                         cmd;
		logic [NUM_LANES-1:0][RW-1:0] r;
		logic                         tir;
	} dv_sb_t;

	logic en;
	logic v_q;

	assign en        = !v_q || result.ready;
	assign ray.ready = en;

	// input conversion
	logic signed [VW-1:0] d_in  [NUM_LANES];
	logic signed [VW-1:0] nv_in [NUM_LANES];
	logic [NW-1:0]        n_in;

	assign d_in[0]  = ray.dir_x[FRAC_BITS+1:H];
	assign d_in[1]  = ray.dir_y[FRAC_BITS+1:H];
	assign d_in[2]  = ray.dir_z[FRAC_BITS+1:H];
	assign nv_in[0] = ray.norm_x[FRAC_BITS+1:H];
	assign nv_in[1] = ray.norm_y[FRAC_BITS+1:H];
	assign nv_in[2] = ray.norm_z[FRAC_BITS+1:H];
	assign n_in     = (ray.index_ratio[FRAC_BITS+3:H] == '0) ? NW'(1)
	                                                         : ray.index_ratio[FRAC_BITS+3:H];

	// stage 1: component products and index square
	logic                 v_s1;
	logic signed [VW-1:0] d_s1  [NUM_LANES];
	logic signed [VW-1:0] nv_s1 [NUM_LANES];
	logic signed [PW-1:0] p_s1  [NUM_LANES];
	logic [NW-1:0]        n_s1;
	logic [NNW-1:0]       nn_s1;
	logic                 cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= ray.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				d_s1[i]  <= d_in[i];
				nv_s1[i] <= nv_in[i];
				p_s1[i]  <= PW'(d_in[i]) * PW'(nv_in[i]);
			end
			n_s1   <= n_in;
			nn_s1  <= NNW'(n_in) * NNW'(n_in);
			cmd_s1 <= ray.command;
		end
	end

	// stage 2: dot product
	logic                   v_s2;
	logic signed [VW-1:0]   d_s2  [NUM_LANES];
	logic signed [VW-1:0]   nv_s2 [NUM_LANES];
	logic signed [DOTW-1:0] dot_s2;
	logic [NW-1:0]          n_s2;
	logic [NNW-1:0]         nn_s2;
	logic                   cmd_s2;
	logic signed [SUMW-1:0] sum_c;

	assign sum_c = SUMW'(p_s1[0]) + SUMW'(p_s1[1]) + SUMW'(p_s1[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2   <= d_s1;
			nv_s2  <= nv_s1;
			dot_s2 <= DOTW'(sum_c >>> P);
			n_s2   <= n_s1;
			nn_s2  <= nn_s1;
			cmd_s2 <= cmd_s1;
		end
	end

	// stage 3: normal times dot, dot squared
	logic                   v_s3;
	logic signed [VW-1:0]   d_s3  [NUM_LANES];
	logic signed [VW-1:0]   nv_s3 [NUM_LANES];
	logic signed [TW-1:0]   t_s3  [NUM_LANES];
	logic signed [CCW-1:0]  cc_s3;
	logic signed [DOTW-1:0] dot_s3;
	logic [NW-1:0]          n_s3;
	logic [NNW-1:0]         nn_s3;
	logic                   cmd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				t_s3[i] <= TW'(nv_s2[i]) * TW'(dot_s2);
			end
			cc_s3  <= CCW'(dot_s2) * CCW'(dot_s2);
			d_s3   <= d_s2;
			nv_s3  <= nv_s2;
			dot_s3 <= dot_s2;
			n_s3   <= n_s2;
			nn_s3  <= nn_s2;
			cmd_s3 <= cmd_s2;
		end
	end

	// stage 4: reflection and radicand
	logic signed [TW:0]     t2_c [NUM_LANES];
	logic signed [TW-P:0]   ts_c [NUM_LANES];
	logic signed [RW-1:0]   r_c  [NUM_LANES];
	logic signed [RADW-1:0] nn_x;
	logic signed [RADW-1:0] cc_x;
	logic signed [RADW-1:0] one_sq;
	logic signed [RADW-1:0] rad_c;

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			t2_c[i] = (TW+1)'(t_s3[i]) <<< 1;
			ts_c[i] = (TW+1-P)'(t2_c[i] >>> P);
			r_c[i]  = RW'(d_s3[i]) - RW'(ts_c[i]);
		end
	end

	assign nn_x   = RADW'(nn_s3);
	assign cc_x   = RADW'(cc_s3);
	assign one_sq = RADW'(1) <<< (2 * P);
	assign rad_c  = nn_x - one_sq + cc_x;

	logic            v_s4;
	sq_sb_t          sb_s4;
	logic [RADW-1:0] rad_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				sb_s4.d[i]  <= d_s3[i];
				sb_s4.nv[i] <= nv_s3[i];
				sb_s4.r[i]  <= r_c[i];
			end
			sb_s4.n   <= n_s3;
			sb_s4.cmd <= cmd_s3;
			sb_s4.dot <= dot_s3;
			sb_s4.tir <= rad_c[RADW-1];
			rad_s4    <= rad_c;
		end
	end

	// square root of the radicand
	logic          v_sq;
	logic [KW-1:0] k_sq;
	sq_sb_t        sb_sq;

	rrr_sqrt_pipe #(
		.XW  (RADW),
		.SBW ($bits(sq_sb_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.x         (rad_s4),
		.sb_in     (sb_s4),
		.out_valid (v_sq),
		.root      (k_sq),
		.sb_out    (sb_sq)
	);

	// stage 5: m = k + c
	logic signed [MW-1:0] k_x;
	logic signed [MW-1:0] dot_x;
	logic                 v_s5;
	sq_sb_t               sb_s5;
	logic signed [MW-1:0] m_s5;

	assign k_x   = MW'(k_sq);
	assign dot_x = MW'($signed(sb_sq.dot));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_sq;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s5 <= sb_sq;
			m_s5  <= k_x + dot_x;
		end
	end

	// stage 6: numerator d*ONE - m*nv
	logic                         v_s6;
	logic signed [AW-1:0]         a_s6 [NUM_LANES];
	logic [NW-1:0]                n_s6;
	logic                         cmd_s6;
	logic [NUM_LANES-1:0][RW-1:0] r_s6;
	logic                         tir_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				a_s6[i] <= (AW'($signed(sb_s5.d[i])) <<< P)
				         - AW'(m_s5) * AW'($signed(sb_s5.nv[i]));
			end
			n_s6   <= sb_s5.n;
			cmd_s6 <= sb_s5.cmd;
			r_s6   <= sb_s5.r;
			tir_s6 <= sb_s5.tir;
		end
	end

	// stage 7: magnitude with floor bias for negative numerators
	logic [AW-1:0]                 ua_c [NUM_LANES];
	logic                          v_s7;
	logic [NUM_LANES-1:0][AW-1:0]  u_s7;
	logic [NW-1:0]                 n_s7;
	dv_sb_t                        sb_s7;

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			ua_c[i] = a_s6[i][AW-1] ? AW'(-a_s6[i]) + AW'(n_s6 - NW'(1)) : AW'(a_s6[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				u_s7[i]      <= ua_c[i];
				sb_s7.neg[i] <= a_s6[i][AW-1];
			end
			n_s7      <= n_s6;
			sb_s7.cmd <= cmd_s6;
			sb_s7.r   <= r_s6;
			sb_s7.tir <= tir_s6;
		end
	end

	// division by the index
	logic                         v_dv;
	logic [NUM_LANES-1:0][QB-1:0] q_dv;
	logic [NUM_LANES-1:0]         ovf_dv;
	dv_sb_t                       sb_dv;

	rrr_div_pipe #(
		.UW  (AW),
		.DW  (NW),
		.QB  (QB),
		.SBW ($bits(dv_sb_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.num       (u_s7),
		.divisor   (n_s7),
		.sb_in     (sb_s7),
		.out_valid (v_dv),
		.quo       (q_dv),
		.ovf       (ovf_dv),
		.sb_out    (sb_dv)
	);

	// output select, saturation and scaling
	logic                 refr_c;
	logic signed [RW-1:0] rr_c   [NUM_LANES];
	logic signed [VW-1:0] sv_c   [NUM_LANES];
	logic                 sat_hi [NUM_LANES];
	logic [OW-1:0]        o_c    [NUM_LANES];
	logic [OW-1:0]        o_q    [NUM_LANES];
	logic                 flag_q;

	assign refr_c = sb_dv.cmd && !sb_dv.tir;

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			rr_c[i]   = $signed(sb_dv.r[i]);
			sat_hi[i] = 1'b0;
			if (refr_c) begin
				if (ovf_dv[i]) begin
					sv_c[i]   = sb_dv.neg[i] ? VMIN : VMAX;
					sat_hi[i] = !sb_dv.neg[i];
				end else if (sb_dv.neg[i]) begin
					sv_c[i] = (q_dv[i] > QLIM) ? VMIN : -$signed(q_dv[i]);
				end else begin
					sv_c[i]   = q_dv[i][QB-1] ? VMAX : $signed(q_dv[i]);
					sat_hi[i] = q_dv[i][QB-1];
				end
			end else begin
				if (rr_c[i] > RMAX) begin
					sv_c[i]   = VMAX;
					sat_hi[i] = 1'b1;
				end else if (rr_c[i] < RMIN) begin
					sv_c[i] = VMIN;
				end else begin
					sv_c[i] = rr_c[i][VW-1:0];
				end
			end
			// positive saturation takes the full output range
			o_c[i] = sat_hi[i] ? OMAX : (OW'(sv_c[i]) <<< H);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_q    <= o_c;
			flag_q <= refr_c;
		end
	end

	assign result.valid          = v_q;
	assign result.out_x          = o_q[0];
	assign result.out_y          = o_q[1];
	assign result.out_z          = o_q[2];
	assign result.refracted_flag = flag_q;

endmodule
